FILE: rtl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants of the 128-bit Blum Blum Shub generator.
// ----------------------------------------------------------------------------
package bbs_pkg;

  localparam int unsigned STATE_W = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned BIT_W   = 7;   // indexes the 128 multiplier bits
  localparam int unsigned DIGIT_W = 4;   // output word shift per squaring

  localparam logic [HALF_W-1:0] PRIME_P = 64'd10650232656610726727;
  localparam logic [HALF_W-1:0] PRIME_Q = 64'd10650232656628286999;
  localparam logic [STATE_W-1:0] MODULUS =
    STATE_W'(PRIME_P) * STATE_W'(PRIME_Q);

  localparam logic [STATE_W-1:0] STATE_RESET = 128'd3;

  // input kinds carried on tuser
  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_GEN  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_ADD,
    ST_RED,
    ST_DONE
  } bbs_state_t;

endpackage

FILE: rtl/bbs_128bit_generator_unit.sv
// ----------------------------------------------------------------------------
// bbs_128bit_generator_unit
// Blum Blum Shub generator over a fixed 128-bit modulus, bit-serial datapath.
// ----------------------------------------------------------------------------
// A transaction with tuser = 0 loads the 128-bit seed in tdata into the state,
// reduced modulo M = P*Q, and produces no output. A transaction with tuser = 1
// squares the state modulo M ROUNDS times; after each squaring the 64-bit
// output word is shifted left by 4 and XORed with the low half of the new
// state, and one output transaction carries that word and the low state half.
// Each squaring scans the 128 bits of x from the top through a shift register:
// an ADD step doubles the partial product and adds x when the bit is set, then
// RED steps check and subtract M until the partial product is below M (one to
// three checks). After an accepted generate transaction, the next input is
// accepted only when all ROUNDS squarings of the bit-serial scan are done and
// the finished word has gone to the output register, which may first have to
// wait for that register to free up. One transaction is in work at a time; a
// finished result waits in the output register while the next input
// transaction is taken.
module bbs_128bit_generator_unit #(
  parameter int unsigned ROUNDS = 16   // squarings per generate, 1..64
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] seed_low, [127:64] seed_high
  input  logic [0:0]   in_tuser,   // [0] action
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // [63:0] rand_word, [127:64] state_low
);
  import bbs_pkg::*;

  localparam int unsigned RND_W = $clog2(ROUNDS + 1);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(STATE_W - 1);

  // FSM and datapath registers
  bbs_state_t           state_r, state_nxt;
  logic [STATE_W-1:0]   x_r, x_nxt;        // generator state
  logic [STATE_W-1:0]   xs_r, xs_nxt;      // multiplier bits, MSB first
  logic [STATE_W:0]     acc_r, acc_nxt;    // partial product, below 3M
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [RND_W-1:0]     rnd_r, rnd_nxt;
  logic [HALF_W-1:0]    word_r, word_nxt;  // output word being built
  logic                 out_vld_r, out_vld_nxt;
  logic [2*HALF_W-1:0]  out_data_r, out_data_nxt;

  logic                 in_hs;
  logic                 out_free;
  logic [STATE_W+1:0]   diff;
  logic                 below_m;
  logic [STATE_W:0]     addend;

  assign in_hs    = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;

  // one subtractor: borrow says the partial product is already below M
  assign diff    = {1'b0, acc_r} - {2'b00, MODULUS};
  assign below_m = diff[STATE_W+1];
  assign addend  = xs_r[STATE_W-1] ? {1'b0, x_r} : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_hs) begin
          state_nxt = (in_tuser[0] == ACT_SEED) ? ST_SEED : ST_ADD;
        end
      end
      ST_SEED: begin
        if (below_m) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD: state_nxt = ST_RED;
      ST_RED: begin
        if (below_m) begin
          if (bit_r == BIT_LAST && rnd_r == RND_LAST) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_ADD;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    x_nxt        = x_r;
    xs_nxt       = xs_r;
    acc_nxt      = acc_r;
    bit_nxt      = bit_r;
    rnd_nxt      = rnd_r;
    word_nxt     = word_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_hs) begin
          if (in_tuser[0] == ACT_SEED) begin
            acc_nxt = {1'b0, in_tdata};
          end else begin
            acc_nxt  = '0;
            xs_nxt   = x_r;
            bit_nxt  = '0;
            rnd_nxt  = '0;
            word_nxt = x_r[HALF_W-1:0];
          end
        end
      end
      ST_SEED: begin
        // subtract M until the seed is below it
        if (below_m) begin
          x_nxt = acc_r[STATE_W-1:0];
        end else begin
          acc_nxt = diff[STATE_W:0];
        end
      end
      ST_ADD: begin
        // double, add x when the current multiplier bit is set
        acc_nxt = {acc_r[STATE_W-1:0], 1'b0} + addend;
        xs_nxt  = {xs_r[STATE_W-2:0], 1'b0};
      end
      ST_RED: begin
        if (!below_m) begin
          acc_nxt = diff[STATE_W:0];
        end else if (bit_r == BIT_LAST) begin
          // squaring complete: commit state, fold into output word
          x_nxt    = acc_r[STATE_W-1:0];
          word_nxt = {word_r[HALF_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                     ^ acc_r[HALF_W-1:0];
          acc_nxt  = '0;
          xs_nxt   = acc_r[STATE_W-1:0];
          bit_nxt  = '0;
          rnd_nxt  = rnd_r + RND_W'(1);
        end else begin
          bit_nxt = bit_r + BIT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {x_r[HALF_W-1:0], word_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      x_r       <= STATE_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      x_r       <= x_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    xs_r       <= xs_nxt;
    acc_r      <= acc_nxt;
    bit_r      <= bit_nxt;
    rnd_r      <= rnd_nxt;
    word_r     <= word_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
